// File: sv/pcb_pkg.sv
// Shared constants and types for the piece completion bitmap
`timescale 1ns / 1ps

package pcb_pkg;

  // fixed field widths
  localparam int unsigned TOTAL_W = 23;
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned DONE_W  = 13;
  localparam int unsigned OP_W    = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_SET   = 2'd1;
  localparam logic [OP_W-1:0] OP_TEST  = 2'd2;

  // control state of the tracker
  typedef enum logic {
    ST_RUN,
    ST_CLEAR
  } state_e;

endpackage

// File: sv/pcb_in_if.sv
// Input item channel: operation and piece index
`timescale 1ns / 1ps

interface pcb_in_if;
  logic                        valid;
  logic                        ready;
  logic [pcb_pkg::OP_W-1:0]    operation;
  logic [pcb_pkg::IDX_W-1:0]   piece_num;

  modport source (output valid, output operation, output piece_num, input ready);
  modport sink   (input valid, input operation, input piece_num, output ready);
endinterface

// File: sv/pcb_out_if.sv
// Result channel: flags and progress counters
`timescale 1ns / 1ps

interface pcb_out_if;
  logic                          valid;
  logic                          ready;
  logic                          newly_set;
  logic                          bit_value;
  logic                          out_of_range;
  logic [pcb_pkg::DONE_W-1:0]    pieces_done;
  logic [pcb_pkg::TOTAL_W-1:0]   bytes_done;
  logic                          all_present;

  modport source (output valid, output newly_set, output bit_value, output out_of_range,
                  output pieces_done, output bytes_done, output all_present,
                  input ready);
  modport sink   (input valid, input newly_set, input bit_value, input out_of_range,
                  input pieces_done, input bytes_done, input all_present,
                  output ready);
endinterface

// File: sv/pcb_ram.sv
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps

module pcb_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/pcb_div.sv
// Division by the fixed piece size: reciprocal multiply, then remainder, each step registered
`timescale 1ns / 1ps

module pcb_div #(
  parameter int unsigned DIVISOR = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [pcb_pkg::TOTAL_W-1:0]         dividend_i,
  output logic                                busy_o,
  output logic [pcb_pkg::TOTAL_W-1:0]         quot_o,
  output logic [$clog2(DIVISOR + 1)-1:0]      rem_o
);

  localparam int unsigned REM_W  = $clog2(DIVISOR + 1);
  localparam int unsigned SHIFT  = pcb_pkg::TOTAL_W + $clog2(DIVISOR);
  localparam int unsigned RCP_W  = pcb_pkg::TOTAL_W + 1;
  localparam int unsigned PROD_W = pcb_pkg::TOTAL_W + RCP_W;
  // rounded-up reciprocal, exact for every dividend of TOTAL_W bits
  localparam logic [63:0] SCALE  = 64'd1 << SHIFT;
  localparam logic [63:0] RECIP  = (SCALE + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

  logic [pcb_pkg::TOTAL_W-1:0] num_q, num_d;
  logic [pcb_pkg::TOTAL_W-1:0] quot_q, quot_d;
  logic [REM_W-1:0]            rem_q, rem_d;
  logic                        quot_pend_q, quot_pend_d;
  logic                        rem_pend_q, rem_pend_d;
  logic [PROD_W-1:0]           prod;
  logic [pcb_pkg::TOTAL_W-1:0] back;

  // quotient by reciprocal multiply, then remainder by multiply-back and subtract
  always_comb begin
    prod        = PROD_W'(num_q) * PROD_W'(RECIP);
    back        = quot_q * pcb_pkg::TOTAL_W'(DIVISOR);
    num_d       = num_q;
    quot_d      = quot_q;
    rem_d       = rem_q;
    quot_pend_d = 1'b0;
    rem_pend_d  = 1'b0;
    if (start_i) begin
      num_d       = dividend_i;
      quot_pend_d = 1'b1;
    end
    if (quot_pend_q) begin
      quot_d     = pcb_pkg::TOTAL_W'(prod >> SHIFT);
      rem_pend_d = 1'b1;
    end
    if (rem_pend_q) begin
      rem_d = REM_W'(num_q - back);
    end
  end

  // step flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quot_pend_q <= 1'b0;
      rem_pend_q  <= 1'b0;
    end else begin
      quot_pend_q <= quot_pend_d;
      rem_pend_q  <= rem_pend_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign busy_o = quot_pend_q || rem_pend_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// File: sv/piece_completion_bitmap.sv
// Top level: piece bitmap in RAM with read-modify-write stage and counters
// Items pass the stage then the result register; the RAM read is forwarded past the write ahead.
// Throughput: one set or test per cycle while the result side takes results.
// A clear holds off input until both of these are done:
//   a sweep zeroes the bitmap RAM one entry per cycle while the piece count is worked out.
// Reset is asynchronous; the sweep then runs and holds off input until it is done.
`timescale 1ns / 1ps

module piece_completion_bitmap #(
  parameter int unsigned MAX_PIECES  = 4096,
  parameter int unsigned PIECE_BYTES = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pcb_pkg::TOTAL_W-1:0]   cfg_wdata_i,
  pcb_in_if.sink                        item_i,
  pcb_out_if.source                     result_o
);

  localparam int unsigned AW    = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_PIECES + 1);
  localparam int unsigned PB_W  = $clog2(PIECE_BYTES + 1);
  localparam int unsigned CMP_W = pcb_pkg::IDX_W + 1;
  localparam int unsigned Q_W   = pcb_pkg::TOTAL_W + 1;

  pcb_pkg::state_e state_q, state_d;

  logic [pcb_pkg::TOTAL_W-1:0] total_bytes_q;
  logic [CNT_W-1:0]            piece_count_q, piece_count_d;
  logic [PB_W-1:0]             last_bytes_q, last_bytes_d;
  logic [CNT_W-1:0]            marked_count_q, marked_count_d;
  logic [pcb_pkg::TOTAL_W-1:0] marked_bytes_q, marked_bytes_d;
  logic [CNT_W-1:0]            sweep_q, sweep_d;
  logic                        pend_q, pend_d;

  logic                        s1_valid_q, s1_valid_d;
  logic [pcb_pkg::OP_W-1:0]    s1_op_q;
  logic [pcb_pkg::IDX_W-1:0]   s1_idx_q;
  logic                        fwd_q, fwd_d;

  logic                        out_valid_q, out_valid_d;
  logic                        newly_q, newly_d;
  logic                        bit_q, bit_d;
  logic                        oor_q, oor_d;
  logic [CNT_W-1:0]            done_q;
  logic [pcb_pkg::TOTAL_W-1:0] bytes_q;
  logic                        all_q, all_d;

  logic                        in_acc, s1_go, s1_clear, s1_set_we;
  logic                        hit, in_rng, is_last;
  logic                        ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0]               ram_waddr;
  logic                        div_start, div_busy;
  logic [pcb_pkg::TOTAL_W-1:0] div_quot;
  logic [PB_W-1:0]             div_rem;
  logic [Q_W-1:0]              cnt_full;
  logic                        sweep_done;

  // handshake
  assign s1_go    = s1_valid_q && (!out_valid_q || result_o.ready);
  assign s1_clear = s1_valid_q && (s1_op_q == pcb_pkg::OP_CLEAR);
  assign item_i.ready = (state_q == pcb_pkg::ST_RUN) && !s1_clear &&
                        (!s1_valid_q || s1_go);
  assign in_acc   = item_i.valid && item_i.ready;

  // bit lookup, range check and counter update for the item in the stage
  always_comb begin
    hit            = ram_rdata | fwd_q;
    in_rng         = {1'b0, s1_idx_q} < CMP_W'(piece_count_q);
    is_last        = ({1'b0, s1_idx_q} + CMP_W'(1)) == CMP_W'(piece_count_q);
    s1_set_we      = 1'b0;
    newly_d        = 1'b0;
    bit_d          = 1'b0;
    oor_d          = 1'b0;
    marked_count_d = marked_count_q;
    marked_bytes_d = marked_bytes_q;
    all_d          = (marked_count_q == piece_count_q);
    case (s1_op_q)
      pcb_pkg::OP_CLEAR: begin
        marked_count_d = '0;
        marked_bytes_d = '0;
        all_d          = (total_bytes_q == '0);
      end
      pcb_pkg::OP_SET: begin
        if (!in_rng) begin
          oor_d = 1'b1;
        end else if (!hit) begin
          s1_set_we      = 1'b1;
          newly_d        = 1'b1;
          marked_count_d = marked_count_q + CNT_W'(1);
          marked_bytes_d = marked_bytes_q + (is_last ? pcb_pkg::TOTAL_W'(last_bytes_q)
                                                     : pcb_pkg::TOTAL_W'(PIECE_BYTES));
        end
        all_d = (marked_count_d == piece_count_q);
      end
      pcb_pkg::OP_TEST: begin
        if (!in_rng) begin
          oor_d = 1'b1;
        end else begin
          bit_d = hit;
        end
      end
      default: begin
      end
    endcase
  end

  // bitmap ram: stage writes set bits, the sweep writes zeros
  assign sweep_done = (sweep_q == CNT_W'(MAX_PIECES));
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = s1_idx_q[AW-1:0];
    ram_wdata = 1'b1;
    if (state_q == pcb_pkg::ST_CLEAR && !sweep_done) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_q[AW-1:0];
      ram_wdata = 1'b0;
    end else if (s1_go && s1_set_we) begin
      ram_we = 1'b1;
    end
  end

  pcb_ram #(
    .WIDTH (1),
    .DEPTH (MAX_PIECES)
  ) u_bits (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (item_i.piece_num[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // forward a set landing in the same cycle as the read
  assign fwd_d = ram_we && ram_wdata && (ram_waddr == item_i.piece_num[AW-1:0]);

  // piece count divider, started by a clear
  assign div_start = s1_go && s1_clear;

  pcb_div #(
    .DIVISOR (PIECE_BYTES)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (total_bytes_q),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // clear sequencing and geometry commit
  always_comb begin
    state_d       = state_q;
    sweep_d       = sweep_q;
    pend_d        = pend_q;
    piece_count_d = piece_count_q;
    last_bytes_d  = last_bytes_q;
    cnt_full      = {1'b0, div_quot} + Q_W'(div_rem != '0);
    case (state_q)
      pcb_pkg::ST_RUN: begin
        if (div_start) begin
          state_d = pcb_pkg::ST_CLEAR;
          sweep_d = '0;
          pend_d  = 1'b1;
        end
      end
      pcb_pkg::ST_CLEAR: begin
        if (!sweep_done) begin
          sweep_d = sweep_q + CNT_W'(1);
        end
        if (pend_q && !div_busy) begin
          pend_d = 1'b0;
          if (cnt_full > Q_W'(MAX_PIECES)) begin
            piece_count_d = CNT_W'(MAX_PIECES);
            last_bytes_d  = PB_W'(PIECE_BYTES);
          end else begin
            piece_count_d = CNT_W'(cnt_full);
            last_bytes_d  = (div_rem != '0) ? div_rem : PB_W'(PIECE_BYTES);
          end
        end
        if (sweep_done && !pend_q && !div_busy) begin
          state_d = pcb_pkg::ST_RUN;
        end
      end
      default: begin
        state_d = pcb_pkg::ST_RUN;
      end
    endcase
  end

  // stage and output valid
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_go) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // control and tracker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= pcb_pkg::ST_CLEAR;
      sweep_q        <= '0;
      pend_q         <= 1'b0;
      total_bytes_q  <= '0;
      piece_count_q  <= '0;
      last_bytes_q   <= '0;
      marked_count_q <= '0;
      marked_bytes_q <= '0;
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q       <= state_d;
      sweep_q       <= sweep_d;
      pend_q        <= pend_d;
      piece_count_q <= piece_count_d;
      last_bytes_q  <= last_bytes_d;
      s1_valid_q    <= s1_valid_d;
      out_valid_q   <= out_valid_d;
      if (cfg_we_i) begin
        total_bytes_q <= cfg_wdata_i;
      end
      if (s1_go) begin
        marked_count_q <= marked_count_d;
        marked_bytes_q <= marked_bytes_d;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q  <= item_i.operation;
      s1_idx_q <= item_i.piece_num;
      fwd_q    <= fwd_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      newly_q <= newly_d;
      bit_q   <= bit_d;
      oor_q   <= oor_d;
      done_q  <= marked_count_d;
      bytes_q <= marked_bytes_d;
      all_q   <= all_d;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.newly_set    = newly_q;
  assign result_o.bit_value    = bit_q;
  assign result_o.out_of_range = oor_q;
  assign result_o.pieces_done  = pcb_pkg::DONE_W'(done_q);
  assign result_o.bytes_done   = bytes_q;
  assign result_o.all_present  = all_q;

endmodule

// File: sim/piece_completion_bitmap_test.sv
// Self-checking testbench for the piece completion bitmap
`timescale 1ns / 1ps

module piece_completion_bitmap_test;
  import pcb_pkg::*;

  localparam int unsigned MAX_PIECES    = 4096;
  localparam int unsigned PIECE_BYTES   = 1024;
  localparam logic [OP_W-1:0] OP_IDLE   = 2'd3;
  // a clear sweeps the whole bitmap, so let it finish before touching the register
  localparam int unsigned SETTLE_CYCLES = MAX_PIECES + 32;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned IDLE_PCT      = 21;
  localparam int unsigned GAP_PCT       = 13;
  localparam int unsigned PHASES        = 9;
  localparam int unsigned PHASE_ITEMS   = 100;

  // one result transaction
  typedef struct packed {
    logic               newly_set;
    logic               bit_value;
    logic               out_of_range;
    logic [DONE_W-1:0]  pieces_done;
    logic [TOTAL_W-1:0] bytes_done;
    logic               all_present;
  } progress_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [TOTAL_W-1:0] cfg_wdata_i;

  pcb_in_if  item_if ();
  pcb_out_if result_if ();

  piece_completion_bitmap #(
    .MAX_PIECES  (MAX_PIECES),
    .PIECE_BYTES (PIECE_BYTES)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_if),
    .result_o    (result_if)
  );

  // tracker state mirrored by the testbench
  bit          piece_seen [MAX_PIECES];
  int unsigned total_len;
  int unsigned piece_total;
  int unsigned tail_bytes;
  int unsigned marked_pieces;
  int unsigned marked_len;

  progress_t   pending_progress [$];
  int unsigned failures;
  bit          gaps_on;
  bit          hold_request;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // apply one operation to the mirrored tracker and return the progress it reports
  function automatic progress_t track_operation(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx);
    progress_t   res;
    int unsigned full_cnt;
    int unsigned rem_len;
    res = '0;
    case (op)
      OP_CLEAR: begin
        full_cnt    = total_len / PIECE_BYTES;
        rem_len     = total_len % PIECE_BYTES;
        piece_total = full_cnt + ((rem_len != 0) ? 1 : 0);
        // too long an object saturates and its last piece is a full one
        if (piece_total > MAX_PIECES) begin
          piece_total = MAX_PIECES;
          rem_len     = 0;
        end
        tail_bytes = (rem_len == 0) ? PIECE_BYTES : rem_len;
        foreach (piece_seen[i]) piece_seen[i] = 1'b0;
        marked_pieces = 0;
        marked_len    = 0;
      end
      OP_SET, OP_TEST: begin
        if (idx >= piece_total) begin
          res.out_of_range = 1'b1;
        end else if (op == OP_TEST) begin
          res.bit_value = piece_seen[idx];
        end else if (!piece_seen[idx]) begin
          piece_seen[idx] = 1'b1;
          res.newly_set   = 1'b1;
          marked_pieces++;
          marked_len += (idx == piece_total - 1) ? tail_bytes : PIECE_BYTES;
        end
      end
      default: ;
    endcase
    res.pieces_done = marked_pieces[DONE_W-1:0];
    res.bytes_done  = marked_len[TOTAL_W-1:0];
    res.all_present = (marked_pieces == piece_total);
    return res;
  endfunction

  // offer one item, wait for the transaction, then record what it should report
  task automatic send_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx);
    if (gaps_on && $urandom_range(0, 99) < GAP_PCT) begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    item_if.valid     <= 1'b1;
    item_if.operation <= op;
    item_if.piece_num <= idx;
    do @(posedge clk_i); while (!item_if.ready);
    pending_progress.push_back(track_operation(op, idx));
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_drained();
    item_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_progress.size() != 0);
  endtask

  // register write once the block has gone quiet
  task automatic write_total(logic [TOTAL_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    total_len = value;
  endtask

  // mostly valid indices, some at the last piece, some anywhere in the field
  function automatic logic [IDX_W-1:0] pick_index();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (piece_total == 0 || r < 8) return IDX_W'($urandom());
    if (r < 18) return IDX_W'(piece_total - 1);
    return IDX_W'($urandom_range(0, piece_total - 1));
  endfunction

  // object lengths: mostly small enough to fill, some exact, empty, large or any value
  function automatic logic [TOTAL_W-1:0] pick_total();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return TOTAL_W'($urandom_range(1, 40 * PIECE_BYTES));
    if (r < 65) return TOTAL_W'(PIECE_BYTES * $urandom_range(1, 40));
    if (r < 75) return '0;
    if (r < 85) return TOTAL_W'($urandom_range(0, MAX_PIECES * PIECE_BYTES + 2000));
    return TOTAL_W'($urandom());
  endfunction

  // nothing cleared yet: no pieces, everything out of range, all present
  task automatic test_before_clear();
    send_item(OP_SET, '0);
    send_item(OP_TEST, '0);
    send_item(OP_TEST, '1);
    send_item(OP_IDLE, '1);
  endtask

  // zero length object
  task automatic test_empty_object();
    write_total('0);
    send_item(OP_CLEAR, '0);
    send_item(OP_SET, '0);
    send_item(OP_TEST, '0);
  endtask

  // length a multiple of the piece size, fill it and set one piece twice
  task automatic test_exact_multiple();
    write_total(TOTAL_W'(3 * PIECE_BYTES));
    send_item(OP_CLEAR, '1);
    send_item(OP_SET, IDX_W'(2));
    send_item(OP_SET, IDX_W'(0));
    send_item(OP_SET, IDX_W'(1));
    send_item(OP_SET, IDX_W'(1));
    send_item(OP_TEST, IDX_W'(1));
    send_item(OP_TEST, IDX_W'(3));
  endtask

  // short last piece adds only its remainder
  task automatic test_short_last_piece();
    write_total(TOTAL_W'(2 * PIECE_BYTES + 5));
    send_item(OP_CLEAR, '0);
    send_item(OP_SET, IDX_W'(2));
    send_item(OP_SET, IDX_W'(2));
    send_item(OP_TEST, IDX_W'(2));
    send_item(OP_IDLE, '0);
  endtask

  // largest register value saturates the piece count
  task automatic test_too_long_object();
    write_total('1);
    send_item(OP_CLEAR, '0);
    send_item(OP_SET, IDX_W'(MAX_PIECES - 1));
    send_item(OP_TEST, IDX_W'(MAX_PIECES - 1));
    send_item(OP_TEST, IDX_W'(MAX_PIECES));
    send_item(OP_SET, '1);
  endtask

  // receiver holds off while items keep coming, then the sender waits for the backlog
  task automatic test_output_stall();
    write_total(TOTAL_W'(20 * PIECE_BYTES));
    send_item(OP_CLEAR, '0);
    send_item(OP_TEST, '0);
    gaps_on      = 1'b0;
    hold_request = 1'b1;
    repeat (40) send_item(OP_SET, pick_index());
    gaps_on = 1'b1;
    wait_drained();
  endtask

  // random phases, each with its own object length and a register rewrite midway
  task automatic test_random_phases();
    int unsigned r;
    int unsigned p;
    int unsigned n;
    logic [TOTAL_W-1:0] len;
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       len = TOTAL_W'(MAX_PIECES * PIECE_BYTES);
        1:       len = TOTAL_W'(MAX_PIECES * PIECE_BYTES + 1);
        default: len = pick_total();
      endcase
      // one phase runs without any idling on either side
      gaps_on = (p != 3);
      write_total(len);
      send_item(OP_CLEAR, IDX_W'($urandom()));
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // a new length alone must not disturb the running state
        if (n == PHASE_ITEMS / 2) write_total(pick_total());
        r = $urandom_range(0, 99);
        if (r < 2)       send_item(OP_CLEAR, IDX_W'($urandom()));
        else if (r < 6)  send_item(OP_IDLE, IDX_W'($urandom()));
        else if (r < 55) send_item(OP_SET, pick_index());
        else             send_item(OP_TEST, pick_index());
      end
    end
    gaps_on = 1'b1;
  endtask

  // result side ready, with random stalls and one long hold-off on request
  initial begin
    result_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        result_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        result_if.ready <= !(gaps_on && $urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  // compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin : check_results
    progress_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (pending_progress.size() == 0) begin
        $error("result transaction with nothing expected");
        failures++;
      end else begin
        want = pending_progress.pop_front();
        compare_field("newly_set", want.newly_set, result_if.newly_set);
        compare_field("bit_value", want.bit_value, result_if.bit_value);
        compare_field("out_of_range", want.out_of_range, result_if.out_of_range);
        compare_field("pieces_done", want.pieces_done, result_if.pieces_done);
        compare_field("bytes_done", want.bytes_done, result_if.bytes_done);
        compare_field("all_present", want.all_present, result_if.all_present);
      end
    end
  end

  // run limit
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // test sequence
  initial begin
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= '0;
    item_if.valid     <= 1'b0;
    item_if.operation <= OP_IDLE;
    item_if.piece_num <= '0;
    gaps_on       = 1'b1;
    hold_request  = 1'b0;
    failures      = 0;
    total_len     = 0;
    piece_total   = 0;
    tail_bytes    = 0;
    marked_pieces = 0;
    marked_len    = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_before_clear();
    test_empty_object();
    test_exact_multiple();
    test_short_last_piece();
    test_too_long_object();
    test_output_stall();
    test_random_phases();
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
